>>> design/smpx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpx_pkg
// Shared widths, permutation ROM, gradient lookup and small helpers for the
// 3D simplex noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package smpx_pkg;

  localparam int COORD_W = 32;
  localparam int NOISE_W = 18;
  localparam int GRAD_W  = 24;

  // 3 * 2^31: offset that makes the skew and unskew sums non-negative
  localparam logic [33:0] DIV3_OFFSET = 34'h1_8000_0000;
  // (2^32 - 1) / 3
  localparam logic [31:0] DIV3_RECIP  = 32'h5555_5555;

  typedef struct packed {
    logic mul;
    logic cor;
  } div_en_t;

  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } gvec_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // h mod 12 via reciprocal 171/2048, exact for 8-bit h
  function automatic logic [3:0] mod12(input logic [7:0] h);
    logic [15:0] p;
    logic [7:0]  m;
    p = 16'(h) * 16'd171;
    m = h - 8'(p[15:11]) * 8'd12;
    return m[3:0];
  endfunction

  function automatic gvec_t grad_vec(input logic [3:0] gi);
    gvec_t g;
    case (gi)
      4'd0:    g = '{2'sd1,  2'sd1,  2'sd0};
      4'd1:    g = '{-2'sd1, 2'sd1,  2'sd0};
      4'd2:    g = '{2'sd1,  -2'sd1, 2'sd0};
      4'd3:    g = '{-2'sd1, -2'sd1, 2'sd0};
      4'd4:    g = '{2'sd1,  2'sd0,  2'sd1};
      4'd5:    g = '{-2'sd1, 2'sd0,  2'sd1};
      4'd6:    g = '{2'sd1,  2'sd0,  -2'sd1};
      4'd7:    g = '{-2'sd1, 2'sd0,  -2'sd1};
      4'd8:    g = '{2'sd0,  2'sd1,  2'sd1};
      4'd9:    g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd10:   g = '{2'sd0,  2'sd1,  -2'sd1};
      4'd11:   g = '{2'sd0,  -2'sd1, -2'sd1};
      default: g = '{2'sd0,  2'sd0,  2'sd0};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> design/smpx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpx_if
// Valid/ready channels for input points and noise results.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpx_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smpx_pkg::COORD_W-1:0]    coord_x;
  logic signed [smpx_pkg::COORD_W-1:0]    coord_y;
  logic signed [smpx_pkg::COORD_W-1:0]    coord_z;
  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                output ready);
endinterface

interface smpx_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smpx_pkg::NOISE_W-1:0]    noise_value;
  logic signed [smpx_pkg::GRAD_W-1:0]     grad_x;
  logic signed [smpx_pkg::GRAD_W-1:0]     grad_y;
  logic signed [smpx_pkg::GRAD_W-1:0]     grad_z;
  modport source (output valid, output noise_value, output grad_x, output grad_y,
                  output grad_z, input ready);
  modport sink (input valid, input noise_value, input grad_x, input grad_y,
                input grad_z, output ready);
endinterface

`default_nettype wire

>>> design/simplex_noise_3d_with_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_3d_with_gradient
// 3D simplex noise with analytic gradient, fixed point, fully pipelined.
// Pipeline: 17 register stages; a result word is valid once it reaches the
// last stage and leaves when res.ready is high.
// Throughput: one word per cycle unless res.ready stalls the output; each
// stage holds one word, freed as soon as the next takes it; bubbles close up.
// Reset clears the stage valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module simplex_noise_3d_with_gradient #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  smpx_in_if.sink       pt,
  smpx_out_if.source    res
);

  localparam int F   = FRAC_BITS;
  localparam int NS  = 17;
  localparam int DW  = F + 3;
  localparam int ONE = 1 << F;
  localparam int G1  = (ONE + 3) / 6;
  localparam int G2  = (2 * ONE + 3) / 6;
  localparam int G3  = ONE / 2;
  localparam int T1  = ONE / 6;
  localparam int T2  = ONE / 3;
  localparam int NSW = F + 8;
  localparam int DSW = F + 11;
  localparam int GSW = F + 4;
  localparam int NW  = F + 14;
  localparam int GW  = F + 21;
  localparam int NOISE_MAX = (1 << (smpx_pkg::NOISE_W - 1)) - 1;
  localparam int GRAD_MAX  = (1 << (smpx_pkg::GRAD_W - 1)) - 1;

  localparam logic signed [DW-1:0] G1P = DW'(G1);
  localparam logic signed [DW-1:0] G1M = DW'(G1 - ONE);
  localparam logic signed [DW-1:0] G2P = DW'(G2);
  localparam logic signed [DW-1:0] G2M = DW'(G2 - ONE);
  localparam logic signed [DW-1:0] G3M = DW'(G3 - ONE);
  localparam logic [DW-1:0] T1_W = DW'(T1);
  localparam logic [DW-1:0] T2_W = DW'(T2);
  localparam logic signed [NW-1:0] N_HI = NW'(NOISE_MAX);
  localparam logic signed [NW-1:0] N_LO = NW'(-NOISE_MAX - 1);
  localparam logic signed [GW-1:0] G_HI = GW'(GRAD_MAX);
  localparam logic signed [GW-1:0] G_LO = GW'(-GRAD_MAX - 1);

  // stage valids and advance enables
  logic [NS:1]   vld;
  logic [NS:0]   vchain;
  logic [NS+1:1] en;

  assign vchain    = {vld, pt.valid};
  assign pt.ready  = en[1];
  assign res.valid = vld[NS];

  always_comb begin
    en[NS+1] = res.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) vld[k] <= vchain[k-1];
      end
    end
  end

  // skew: s = floor((x+y+z)/3)
  logic signed [31:0] s1_c [3];
  logic signed [31:0] s2_c [3];
  logic signed [31:0] s3_c [3];
  logic signed [31:0] s4_c [3];
  logic [33:0]        s1_sum;
  logic [33:0]        qs;
  logic [1:0]         rs_unused;
  logic signed [31:0] s_val;
  logic signed [32:0] s4_xs [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_c[0] <= pt.coord_x;
      s1_c[1] <= pt.coord_y;
      s1_c[2] <= pt.coord_z;
      s1_sum  <= 34'(pt.coord_x) + 34'(pt.coord_y) + 34'(pt.coord_z)
                 + smpx_pkg::DIV3_OFFSET;
    end
    if (en[2]) s2_c <= s1_c;
    if (en[3]) s3_c <= s2_c;
  end

  smpx_div3 u_div_skew (
    .clk (clk),
    .en  ('{mul: en[2], cor: en[3]}),
    .num (s1_sum),
    .quo (qs),
    .rem (rs_unused)
  );

  assign s_val = {~qs[31], qs[30:0]};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int a = 0; a < 3; a++) begin
        s4_xs[a] <= 33'(s3_c[a]) + 33'(s_val);
        s4_c[a]  <= s3_c[a];
      end
    end
  end

  // unskew: t = floor((i+j+k)*ONE/6) = floor(n/3)*ONE/2 + floor((n mod 3)*ONE/6)
  logic signed [32-F:0] cell_idx [3];
  logic [33:0]          s5_n;
  logic [7:0]           s5_cl [3];
  logic [7:0]           s6_cl [3];
  logic [7:0]           s7_cl [3];
  logic [DW-1:0]        s5_xl [3];
  logic [DW-1:0]        s6_xl [3];
  logic [DW-1:0]        s7_xl [3];
  logic [33:0]          qn;
  logic [1:0]           rn;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_idx[a] = $signed(s4_xs[a][32:F]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_n <= 34'(cell_idx[0]) + 34'(cell_idx[1]) + 34'(cell_idx[2])
              + smpx_pkg::DIV3_OFFSET;
      for (int a = 0; a < 3; a++) begin
        s5_cl[a] <= s4_xs[a][F+7:F];
        s5_xl[a] <= s4_c[a][DW-1:0];
      end
    end
    if (en[6]) begin
      s6_cl <= s5_cl;
      s6_xl <= s5_xl;
    end
    if (en[7]) begin
      s7_cl <= s6_cl;
      s7_xl <= s6_xl;
    end
  end

  smpx_div3 u_div_unskew (
    .clk (clk),
    .en  ('{mul: en[6], cor: en[7]}),
    .num (s5_n),
    .quo (qn),
    .rem (rn)
  );

  logic [DW-1:0]        t_low;
  logic signed [DW-1:0] s8_p [3];
  logic [7:0]           s8_cl [3];

  always_comb begin
    t_low = {qn[3:0], {(F-1){1'b0}}};
    case (rn)
      2'd1:    t_low = t_low + T1_W;
      2'd2:    t_low = t_low + T2_W;
      default: t_low = t_low;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int a = 0; a < 3; a++) begin
        s8_p[a]  <= $signed(s7_xl[a] - {s7_cl[a][2:0], {F{1'b0}}} + t_low);
        s8_cl[a] <= s7_cl[a];
      end
    end
  end

  // tetrahedron choice and corner offsets
  logic [2:0] b1, b2;
  logic       xy, yz, xz;
  logic signed [DW-1:0] s9_d [4][3];
  logic [7:0]           s9_h [4][3];

  assign xy = s8_p[0] >= s8_p[1];
  assign yz = s8_p[1] >= s8_p[2];
  assign xz = s8_p[0] >= s8_p[2];

  // b1/b2 bit a is the step along axis a (x is bit 0)
  always_comb begin
    if (xy) begin
      if (yz) begin
        b1 = 3'b001; b2 = 3'b011;
      end else if (xz) begin
        b1 = 3'b001; b2 = 3'b101;
      end else begin
        b1 = 3'b100; b2 = 3'b101;
      end
    end else begin
      if (!yz) begin
        b1 = 3'b100; b2 = 3'b110;
      end else if (!xz) begin
        b1 = 3'b010; b2 = 3'b110;
      end else begin
        b1 = 3'b010; b2 = 3'b011;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int a = 0; a < 3; a++) begin
        s9_d[0][a] <= s8_p[a];
        s9_d[1][a] <= s8_p[a] + (b1[a] ? G1M : G1P);
        s9_d[2][a] <= s8_p[a] + (b2[a] ? G2M : G2P);
        s9_d[3][a] <= s8_p[a] + G3M;
        s9_h[0][a] <= s8_cl[a];
        s9_h[1][a] <= s8_cl[a] + 8'(b1[a]);
        s9_h[2][a] <= s8_cl[a] + 8'(b2[a]);
        s9_h[3][a] <= s8_cl[a] + 8'd1;
      end
    end
  end

  // corners: stages 10 to 15
  logic signed [F+5:0] nt [4];
  logic signed [F+8:0] dt [4][3];
  logic signed [F+1:0] gt [4][3];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    smpx_corner #(.FRAC_BITS(F)) u_corner (
      .clk   (clk),
      .en    (en[15:10]),
      .d_in  (s9_d[c]),
      .h_in  (s9_h[c]),
      .nterm (nt[c]),
      .dterm (dt[c]),
      .gterm (gt[c])
    );
  end

  // sums and scaling: noise = 32*n, grad = 32*(g - 8*d)
  logic signed [NSW-1:0] nsum;
  logic signed [DSW-1:0] dsum [3];
  logic signed [GSW-1:0] gsum [3];
  logic signed [NW-1:0]  s16_n;
  logic signed [GW-1:0]  s16_g [3];

  always_comb begin
    nsum = NSW'(nt[0]) + NSW'(nt[1]) + NSW'(nt[2]) + NSW'(nt[3]);
    for (int a = 0; a < 3; a++) begin
      dsum[a] = DSW'(dt[0][a]) + DSW'(dt[1][a]) + DSW'(dt[2][a]) + DSW'(dt[3][a]);
      gsum[a] = GSW'(gt[0][a]) + GSW'(gt[1][a]) + GSW'(gt[2][a]) + GSW'(gt[3][a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[16]) begin
      s16_n <= NW'(nsum) <<< 5;
      for (int a = 0; a < 3; a++) begin
        s16_g[a] <= (GW'(gsum[a]) - (GW'(dsum[a]) <<< 3)) <<< 5;
      end
    end
  end

  // saturation and result register
  logic signed [smpx_pkg::GRAD_W-1:0] s17_g [3];

  always_ff @(posedge clk) begin
    if (en[17]) begin
      if (s16_n > N_HI) begin
        res.noise_value <= smpx_pkg::NOISE_W'(N_HI);
      end else if (s16_n < N_LO) begin
        res.noise_value <= smpx_pkg::NOISE_W'(N_LO);
      end else begin
        res.noise_value <= smpx_pkg::NOISE_W'(s16_n);
      end
      for (int a = 0; a < 3; a++) begin
        if (s16_g[a] > G_HI) begin
          s17_g[a] <= smpx_pkg::GRAD_W'(G_HI);
        end else if (s16_g[a] < G_LO) begin
          s17_g[a] <= smpx_pkg::GRAD_W'(G_LO);
        end else begin
          s17_g[a] <= smpx_pkg::GRAD_W'(s16_g[a]);
        end
      end
    end
  end

  assign res.grad_x = s17_g[0];
  assign res.grad_y = s17_g[1];
  assign res.grad_z = s17_g[2];

endmodule

`default_nettype wire

>>> design/smpx_div3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpx_div3
// Two-stage floor division of a 34-bit unsigned word by three: reciprocal
// multiply, then a small remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module smpx_div3 (
  input  logic                clk,
  input  smpx_pkg::div_en_t   en,
  input  logic [33:0]         num,
  output logic [33:0]         quo,
  output logic [1:0]          rem
);

  logic [63:0] prod;
  logic [33:0] qa;
  logic [33:0] na;
  logic [35:0] r;
  logic [1:0]  corr;
  logic [3:0]  rfix;

  assign prod = 64'(num[33:2]) * 64'(smpx_pkg::DIV3_RECIP);

  // estimate is low by at most two
  always_comb begin
    r = 36'(na) - (36'(qa) + {1'b0, qa, 1'b0});
    if (r[3:0] >= 4'd6) begin
      corr = 2'd2;
    end else if (r[3:0] >= 4'd3) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    rfix = r[3:0] - 4'(corr) - {1'b0, corr, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      qa <= prod[63:30];
      na <= num;
    end
    if (en.cor) begin
      quo <= qa + 34'(corr);
      rem <= rfix[1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/smpx_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpx_corner
// One simplex corner: hash chain through the permutation ROM, falloff
// (0.6 - r^2)^4, dot product and the derivative terms, over six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module smpx_corner #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic [5:0]                    en,
  input  logic signed [FRAC_BITS+2:0]   d_in [3],
  input  logic [7:0]                    h_in [3],
  output logic signed [FRAC_BITS+5:0]   nterm,
  output logic signed [FRAC_BITS+8:0]   dterm [3],
  output logic signed [FRAC_BITS+1:0]   gterm [3]
);

  localparam int F   = FRAC_BITS;
  localparam int DW  = F + 3;
  localparam int ONE = 1 << F;
  localparam int C06 = (6 * ONE + 5) / 10;
  localparam logic [F+6:0] C06_W = (F+7)'(C06);

  logic signed [DW-1:0]    d10 [3];
  logic signed [DW-1:0]    d11 [3];
  logic signed [DW-1:0]    d12 [3];
  logic signed [DW-1:0]    d13 [3];
  logic signed [DW-1:0]    d14 [3];
  logic [7:0]              ic10, jc10, ic11;
  logic [7:0]              h1, h2;
  logic [2*F+4:0]          sq [3];
  logic [2*F+6:0]          sqsum;
  logic [F+6:0]            r2;
  logic [F-1:0]            t11, t12, tt12, t3, t4;
  logic [3:0]              gi;
  logic [2*F-1:0]          p_tt, p_t3, p_t4;
  logic signed [F+4:0]     dot;
  smpx_pkg::gvec_t         gv, g13;
  logic signed [2*F+5:0]   p_n, p_tmp;
  logic signed [F+5:0]     tmp;
  logic signed [2*F+8:0]   p_d [3];
  logic signed [F+5:0]     nterm14;
  logic signed [F+1:0]     gterm14 [3];
  logic signed [DW-1:0]    dd [3];
  logic signed [1:0]       ga [3];

  function automatic logic signed [F+4:0] pick(input logic signed [1:0] g,
                                               input logic signed [DW-1:0] d);
    logic signed [F+4:0] r;
    case (g)
      2'b01:   r = (F+5)'(d);
      2'b11:   r = -(F+5)'(d);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign sqsum = (2*F+7)'(sq[0]) + (2*F+7)'(sq[1]) + (2*F+7)'(sq[2]);
  assign r2    = sqsum[2*F+6:F];
  assign p_tt  = t11 * t11;
  assign p_t3  = tt12 * t12;
  assign p_t4  = tt12 * tt12;
  assign gv    = smpx_pkg::grad_vec(gi);
  assign p_n   = $signed({1'b0, t4}) * dot;
  assign p_tmp = $signed({1'b0, t3}) * dot;
  assign ga[0] = g13.gx;
  assign ga[1] = g13.gy;
  assign ga[2] = g13.gz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a]  = d14[a];
      p_d[a] = tmp * dd[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1   <= smpx_pkg::PERM[h_in[2]];
      ic10 <= h_in[0];
      jc10 <= h_in[1];
      for (int a = 0; a < 3; a++) begin
        sq[a]  <= (2*F+5)'(d_in[a] * d_in[a]);
        d10[a] <= d_in[a];
      end
    end
    if (en[1]) begin
      h2   <= smpx_pkg::PERM[8'(jc10 + h1)];
      ic11 <= ic10;
      t11  <= (r2 > C06_W) ? '0 : F'(C06_W - r2);
      for (int a = 0; a < 3; a++) d11[a] <= d10[a];
    end
    if (en[2]) begin
      gi   <= smpx_pkg::mod12(smpx_pkg::PERM[8'(ic11 + h2)]);
      tt12 <= p_tt[2*F-1:F];
      t12  <= t11;
      for (int a = 0; a < 3; a++) d12[a] <= d11[a];
    end
    if (en[3]) begin
      t3  <= p_t3[2*F-1:F];
      t4  <= p_t4[2*F-1:F];
      g13 <= gv;
      dot <= pick(gv.gx, d12[0]) + pick(gv.gy, d12[1]) + pick(gv.gz, d12[2]);
      for (int a = 0; a < 3; a++) d13[a] <= d12[a];
    end
    if (en[4]) begin
      nterm14 <= (F+6)'(p_n >>> F);
      tmp     <= (F+6)'(p_tmp >>> F);
      for (int a = 0; a < 3; a++) begin
        d14[a] <= d13[a];
        case (ga[a])
          2'b01:   gterm14[a] <= $signed({2'b00, t4});
          2'b11:   gterm14[a] <= -$signed({2'b00, t4});
          default: gterm14[a] <= '0;
        endcase
      end
    end
    if (en[5]) begin
      nterm <= nterm14;
      for (int a = 0; a < 3; a++) begin
        dterm[a] <= (F+9)'(p_d[a] >>> F);
        gterm[a] <= gterm14[a];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/smpx_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpx_chk
// Port-level checks on the noise pipeline's flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module smpx_chk (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [smpx_pkg::NOISE_W-1:0] out_noise
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_noise))
    else $error("result word dropped or changed while stalled");

  // an empty output stage never back-pressures the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result word valid straight after reset");

endmodule

bind simplex_noise_3d_with_gradient smpx_chk u_smpx_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pt.valid),
  .in_ready  (pt.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_noise (res.noise_value)
);

`default_nettype wire
